// ----- hdl/gsl_pkg.sv -----
`default_nettype none

package gsl_pkg;

  // Grid geometry and cell format
  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int VALUE_WIDTH = 24;
  localparam int FRAC_BITS   = 15;
  localparam int MIN_DIM     = 3;

  localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int ACC_W   = VALUE_WIDTH + 2;

  // Fixed field widths of the channels
  localparam int IDX_FIELD_W = 6;
  localparam int CFG_DIM_W   = 7;
  localparam int SWEEP_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [SWEEP_W-1:0]     SWEEP_RESET = SWEEP_W'(1000);
  localparam logic [CFG_DIM_W-1:0]   DIM_RESET   = CFG_DIM_W'(64);
  localparam logic [VALUE_WIDTH-1:0] CELL_ONE    = VALUE_WIDTH'(1) << FRAC_BITS;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_INIT  = 2'd2,
    OP_RUN   = 2'd3
  } gsl_op_e;

  typedef struct packed {
    logic [1:0]                    opcode;
    logic [IDX_FIELD_W-1:0]        row;
    logic [IDX_FIELD_W-1:0]        col;
    logic signed [VALUE_WIDTH-1:0] cell_value;
  } gsl_in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] read_value;
    logic                          status;
  } gsl_out_t;

  typedef struct packed {
    logic [DIM_W-1:0]   rows;
    logic [DIM_W-1:0]   cols;
    logic [SWEEP_W-1:0] sweeps;
  } gsl_dims_t;

  typedef struct packed {
    logic                   we;
    logic [ADDR_W-1:0]      waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]      raddr;
  } gsl_ram_req_t;

  // Row-major cell address, row stride fixed at MAX_COLS
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_FIELD_W-1:0] r,
                                                  input logic [IDX_FIELD_W-1:0] c);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/laplace_gauss_seidel_grid_top.sv -----
// Gauss-Seidel relaxation engine for a 2D Laplace grid of signed Q8.15 cells.
// Command beats enter on in_valid_i/in_ready_o: write cell, read cell,
// initialize grid, run sweeps. Each command yields exactly one result beat on
// out_valid_o/out_ready_i carrying the read value (zero unless a read) and a
// status bit that flags a row or column outside the grid in use.
// Grid size and sweep count are set on the cfg_valid_i/cfg_ready_o write port
// (always ready); write them only while no command is in flight.
// A write or out-of-range access loads its result at accept; a read returns
// the registered RAM output; initialize writes every cell in use; a run with
// zero sweeps answers without touching the grid. A run is bound by the
// single grid RAM read port: four neighbor reads plus one write-back per
// interior cell.
// One command is in flight at a time; the next is taken once the engine is
// idle and the result register is empty or draining, so writes and out-of-range
// accesses sustain one beat per cycle while out_ready_i stays high.
// A stalled receiver holds the result register and blocks new commands.
// Reset restores 64x64 cells and 1000 sweeps; grid contents are undefined
// until written or initialized.
`default_nettype none

module laplace_gauss_seidel_grid_top
  import gsl_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire gsl_in_t               in_data_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      gsl_out_t              out_data_o,
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  gsl_dims_t              dims;
  gsl_ram_req_t           ram_req;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  logic                   res_valid;
  gsl_out_t               res;
  logic                   res_free;
  logic                   out_valid_q, out_valid_d;
  gsl_out_t               out_data_q, out_data_d;

  assign cfg_ready_o = 1'b1;

  gsl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .dims_o      (dims)
  );

  gsl_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .dims_i      (dims),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  gsl_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Result register: free when empty or draining this cycle
  assign res_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- hdl/gsl_ram.sv -----
`default_nettype none

module gsl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/gsl_cfg.sv -----
`default_nettype none

module gsl_cfg
  import gsl_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output      gsl_dims_t             dims_o
);

  logic [CFG_DIM_W-1:0] row_cnt_q, row_cnt_d;
  logic [CFG_DIM_W-1:0] col_cnt_q, col_cnt_d;
  logic [SWEEP_W-1:0]   sweep_cnt_q, sweep_cnt_d;

  // Decode the register write
  always_comb begin
    row_cnt_d   = row_cnt_q;
    col_cnt_d   = col_cnt_q;
    sweep_cnt_d = sweep_cnt_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROW_COUNT:   row_cnt_d   = cfg_data_i[CFG_DIM_W-1:0];
        CFG_COL_COUNT:   col_cnt_d   = cfg_data_i[CFG_DIM_W-1:0];
        CFG_SWEEP_COUNT: sweep_cnt_d = cfg_data_i[SWEEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q   <= DIM_RESET;
      col_cnt_q   <= DIM_RESET;
      sweep_cnt_q <= SWEEP_RESET;
    end else begin
      row_cnt_q   <= row_cnt_d;
      col_cnt_q   <= col_cnt_d;
      sweep_cnt_q <= sweep_cnt_d;
    end
  end

  // Clamp the grid size into the supported range
  always_comb begin
    if (32'(row_cnt_q) < MIN_DIM) begin
      dims_o.rows = DIM_W'(MIN_DIM);
    end else if (32'(row_cnt_q) > MAX_ROWS) begin
      dims_o.rows = DIM_W'(MAX_ROWS);
    end else begin
      dims_o.rows = DIM_W'(row_cnt_q);
    end
    if (32'(col_cnt_q) < MIN_DIM) begin
      dims_o.cols = DIM_W'(MIN_DIM);
    end else if (32'(col_cnt_q) > MAX_COLS) begin
      dims_o.cols = DIM_W'(MAX_COLS);
    end else begin
      dims_o.cols = DIM_W'(col_cnt_q);
    end
    dims_o.sweeps = sweep_cnt_q;
  end

endmodule

`default_nettype wire

// ----- hdl/gsl_engine.sv -----
`default_nettype none

module gsl_engine
  import gsl_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire gsl_in_t                in_data_i,
  input  wire gsl_dims_t              dims_i,
  input  wire logic                   res_free_i,
  output      logic                   res_valid_o,
  output      gsl_out_t               res_o,
  output      gsl_ram_req_t           ram_req_o,
  input  wire logic [VALUE_WIDTH-1:0] ram_rdata_i
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_RDWAIT = 8'b0000_0010,
    ST_INIT   = 8'b0000_0100,
    ST_RLX_N  = 8'b0000_1000,
    ST_RLX_S  = 8'b0001_0000,
    ST_RLX_W  = 8'b0010_0000,
    ST_RLX_E  = 8'b0100_0000,
    ST_RLX_WB = 8'b1000_0000
  } gsl_state_e;

  gsl_state_e state_q, state_d;
  logic [DIM_W-1:0]        row_q, row_d;
  logic [DIM_W-1:0]        col_q, col_d;
  logic [ADDR_W-1:0]       base_q, base_d;
  logic [SWEEP_W-1:0]      sweep_q, sweep_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;

  logic                    oob;
  logic [ADDR_W-1:0]       in_addr;
  logic [ADDR_W-1:0]       cur_addr;
  logic signed [ACC_W-1:0] rd_ext;
  logic signed [ACC_W-1:0] sum;
  logic                    last_col;
  logic                    last_row;

  // Decode the incoming beat
  assign oob = (DIM_W'(in_data_i.row) >= dims_i.rows) ||
               (DIM_W'(in_data_i.col) >= dims_i.cols);
  assign in_addr = cell_addr(in_data_i.row, in_data_i.col);

  // Relaxation datapath
  assign cur_addr = base_q + ADDR_W'(col_q);
  assign rd_ext   = {{2{ram_rdata_i[VALUE_WIDTH-1]}}, ram_rdata_i};
  assign sum      = acc_q + rd_ext;
  assign last_col = (col_q == dims_i.cols - DIM_W'(2));
  assign last_row = (row_q == dims_i.rows - DIM_W'(2));

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    base_d      = base_q;
    sweep_d     = sweep_q;
    acc_d       = acc_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    ram_req_o   = '0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = res_free_i;
        if (in_valid_i && res_free_i) begin
          case (in_data_i.opcode)
            OP_WRITE: begin
              res_valid_o     = 1'b1;
              res_o.status    = oob;
              ram_req_o.we    = !oob;
              ram_req_o.waddr = in_addr;
              ram_req_o.wdata = in_data_i.cell_value;
            end
            OP_READ: begin
              ram_req_o.raddr = in_addr;
              if (oob) begin
                res_valid_o  = 1'b1;
                res_o.status = 1'b1;
              end else begin
                state_d = ST_RDWAIT;
              end
            end
            OP_INIT: begin
              row_d   = '0;
              col_d   = '0;
              base_d  = '0;
              state_d = ST_INIT;
            end
            OP_RUN: begin
              if (dims_i.sweeps == '0) begin
                res_valid_o = 1'b1;
              end else begin
                row_d   = DIM_W'(1);
                col_d   = DIM_W'(1);
                base_d  = ADDR_W'(MAX_COLS);
                sweep_d = dims_i.sweeps;
                state_d = ST_RLX_N;
              end
            end
            default: ;
          endcase
        end
      end

      // Return the read beat
      ST_RDWAIT: begin
        res_valid_o      = 1'b1;
        res_o.read_value = ram_rdata_i;
        state_d          = ST_IDLE;
      end

      // Fill one cell per cycle, first row to one, the rest to zero
      ST_INIT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = base_q + ADDR_W'(col_q);
        ram_req_o.wdata = (row_q == '0) ? CELL_ONE : '0;
        if (col_q == dims_i.cols - DIM_W'(1)) begin
          col_d  = '0;
          row_d  = row_q + DIM_W'(1);
          base_d = base_q + ADDR_W'(MAX_COLS);
          if (row_q == dims_i.rows - DIM_W'(1)) begin
            res_valid_o = 1'b1;
            state_d     = ST_IDLE;
          end
        end else begin
          col_d = col_q + DIM_W'(1);
        end
      end

      // Issue the four neighbor reads, accumulate as data returns
      ST_RLX_N: begin
        ram_req_o.raddr = cur_addr - ADDR_W'(MAX_COLS);
        state_d         = ST_RLX_S;
      end
      ST_RLX_S: begin
        ram_req_o.raddr = cur_addr + ADDR_W'(MAX_COLS);
        acc_d           = rd_ext;
        state_d         = ST_RLX_W;
      end
      ST_RLX_W: begin
        ram_req_o.raddr = cur_addr - ADDR_W'(1);
        acc_d           = sum;
        state_d         = ST_RLX_E;
      end
      ST_RLX_E: begin
        ram_req_o.raddr = cur_addr + ADDR_W'(1);
        acc_d           = sum;
        state_d         = ST_RLX_WB;
      end

      // Write back the floored quarter and advance in row-major order
      ST_RLX_WB: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = cur_addr;
        ram_req_o.wdata = sum[ACC_W-1:2];
        state_d         = ST_RLX_N;
        if (last_col) begin
          col_d = DIM_W'(1);
          if (last_row) begin
            row_d  = DIM_W'(1);
            base_d = ADDR_W'(MAX_COLS);
            if (sweep_q == SWEEP_W'(1)) begin
              res_valid_o = 1'b1;
              state_d     = ST_IDLE;
            end else begin
              sweep_d = sweep_q - SWEEP_W'(1);
            end
          end else begin
            row_d  = row_q + DIM_W'(1);
            base_d = base_q + ADDR_W'(MAX_COLS);
          end
        end else begin
          col_d = col_q + DIM_W'(1);
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Counters and accumulator hold only within a command
  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    col_q   <= col_d;
    base_q  <= base_d;
    sweep_q <= sweep_d;
    acc_q   <= acc_d;
  end

endmodule

`default_nettype wire
